[hw/rtl/grm_pkg.sv]
// ---------------------------------------------------------------------------
// grm_pkg: shared types and constants for the grid ray march core
// Beat layouts, register indexes, outcome codes and the quarter-sine builder.
// ---------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

   localparam int MAP_COLUMNS     = 8;
   localparam int MAP_ROWS        = 8;
   localparam int CELL_SIZE       = 64;
   localparam int ANGLE_STEPS_DEF = 4096;
   localparam int MAX_STEPS       = 65536;

   localparam int COORD_W   = 17;
   localparam int ANGLE_W   = 12;
   localparam int OUTCOME_W = 2;
   localparam int STEPS_W   = 17;
   localparam int MAP_W     = 64;
   localparam int START_W   = 22;
   localparam int STEP_W    = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_WALL_MAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARCH_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARCH_STEP  = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUTCOME_WALL  = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EXIT  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_LIMIT = 2'd2;

   localparam logic [MAP_W-1:0]   WALL_MAP_RST    = 64'd18411174329330271743;
   localparam logic [START_W-1:0] MARCH_START_RST = 22'd1179648;
   localparam logic [STEP_W-1:0]  MARCH_STEP_RST  = 16'd1180;

   // trig values are Q1.14, magnitude up to 16384
   localparam int TRIG_W    = 16;
   localparam int SIN_MAG_W = 15;

   // positions in 2^-30 pixel units, signed
   localparam int POS_W    = 50;
   localparam int FRAC_W   = 30;
   localparam int Q8_SHIFT = 22;

   localparam logic [COORD_W-1:0] COORD_MAX = '1;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [ANGLE_W-1:0] ray_angle;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]   end_x;
      logic [COORD_W-1:0]   end_y;
      logic [ANGLE_W-1:0]   angle_out;
      logic [OUTCOME_W-1:0] outcome;
      logic [STEPS_W-1:0]   steps_taken;
   } rsp_type;

   // Taylor series to x^15 in Q2.30, rounded to Q1.14; elaboration only
   function automatic logic [SIN_MAG_W-1:0] quarter_sin(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rounded;
      term = x;
      sum  = signed'(x);
      for (int n = 0; n < 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n + 2) * (2 * n + 3));
         if ((n & 1) == 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      rounded = (unsigned'(sum) + 64'd32768) >> 16;
      return rounded[SIN_MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/grid_ray_march_core.sv]
// ---------------------------------------------------------------------------
// grid_ray_march_core: fixed-step ray march through an 8x8 wall map
// Sequence: the request beat is taken in ST_IDLE, then ST_REDUCE, the sine and
//   cosine reads, the four multiplies and the march run before rsp_valid rises;
//   a still stalled earlier response holds the finished march until it leaves.
// Requests: one ray at a time, held off by req_stall until the sequencer idles;
//   the march takes one sample per cycle through one pair of position adders,
//   after one shared multiplier forms the four direction products.
// Reset: clears the sequencer and the response valid and loads the register
//   defaults; the sine ROM is constant and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_ray_march_core
   import grm_pkg::*;
#(
   parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QUARTER   = ANGLE_STEPS / 4;
   localparam int ROM_DEPTH = QUARTER + 1;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int IDX_W     = ANGLE_W + 1;
   localparam int PROD_W    = TRIG_W + START_W + 1;
   localparam int PIX_W     = POS_W - 1 - FRAC_W;
   localparam int Q8_W      = POS_W - 1 - Q8_SHIFT;
   localparam int CELL_W    = $clog2(MAP_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RD_SIN,
      ST_RD_COS,
      ST_LD_COS,
      ST_MUL_XS,
      ST_MUL_XD,
      ST_MUL_YS,
      ST_MUL_YD,
      ST_MARCH
   } state_type;

   // configuration registers
   logic [MAP_W-1:0]   wall_map_ff;
   logic [START_W-1:0] start_ff;
   logic [STEP_W-1:0]  step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff <= WALL_MAP_RST;
         start_ff    <= MARCH_START_RST;
         step_ff     <= MARCH_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WALL_MAP:    wall_map_ff <= csr_wdata;
            CSR_MARCH_START: start_ff    <= csr_wdata[START_W-1:0];
            CSR_MARCH_STEP:  step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // quarter-wave sine ROM
   logic [SIN_MAG_W-1:0] sin_table [ROM_DEPTH];
   logic [ROM_AW-1:0]    rom_addr;
   logic [SIN_MAG_W-1:0] rom_data_ff;

   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_sin
      localparam logic [63:0] XK = (TWO_PI_Q30 * 64'(k)) / ANGLE_STEPS;
      assign sin_table[k] = quarter_sin(XK);
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= sin_table[rom_addr];
   end

   function automatic logic [ROM_AW:0] fold_angle(input logic [IDX_W-1:0] k);
      logic [IDX_W-1:0] m;
      logic             neg;
      if (k <= IDX_W'(QUARTER)) begin
         m   = k;
         neg = 1'b0;
      end else if (k <= IDX_W'(2 * QUARTER)) begin
         m   = IDX_W'(2 * QUARTER) - k;
         neg = 1'b0;
      end else if (k <= IDX_W'(3 * QUARTER)) begin
         m   = k - IDX_W'(2 * QUARTER);
         neg = 1'b1;
      end else begin
         m   = IDX_W'(4 * QUARTER) - k;
         neg = 1'b1;
      end
      return {neg, m[ROM_AW-1:0]};
   endfunction

   function automatic logic [COORD_W-1:0] to_q8(input logic signed [POS_W-1:0] p);
      logic [Q8_W-1:0] v;
      v = p[POS_W-2:Q8_SHIFT];
      if (p[POS_W-1]) begin
         return '0;
      end
      if (v > Q8_W'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return v[COORD_W-1:0];
   endfunction

   // sequencer state
   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [ANGLE_W-1:0]        ang_ff, ang_in;
   logic                      neg_ff, neg_in;
   logic signed [TRIG_W-1:0]  sin_ff, sin_in;
   logic signed [TRIG_W-1:0]  cos_ff, cos_in;
   logic signed [PROD_W-1:0]  xs_ff, xs_in;
   logic signed [PROD_W-1:0]  xd_ff, xd_in;
   logic signed [PROD_W-1:0]  ys_ff, ys_in;
   logic signed [PROD_W-1:0]  yd_ff, yd_in;
   logic signed [POS_W-1:0]   px_ff, px_in;
   logic signed [POS_W-1:0]   py_ff, py_in;
   logic [STEPS_W-1:0]        steps_ff, steps_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // angle folding
   logic [IDX_W-1:0]  cos_k;
   logic [ROM_AW:0]   sin_fold;
   logic [ROM_AW:0]   cos_fold;

   always_comb begin
      cos_k = {1'b0, ang_ff} + IDX_W'(QUARTER);
      if (cos_k >= IDX_W'(ANGLE_STEPS)) begin
         cos_k = cos_k - IDX_W'(ANGLE_STEPS);
      end
   end

   assign sin_fold = fold_angle({1'b0, ang_ff});
   assign cos_fold = fold_angle(cos_k);
   assign rom_addr = (state_ff == ST_RD_SIN) ? sin_fold[ROM_AW-1:0] : cos_fold[ROM_AW-1:0];

   logic signed [TRIG_W-1:0] rom_trig;
   logic signed [TRIG_W-1:0] rom_trig_signed;

   assign rom_trig        = signed'(TRIG_W'(rom_data_ff));
   assign rom_trig_signed = neg_ff ? -rom_trig : rom_trig;

   // shared multiplier
   logic signed [TRIG_W-1:0] mul_a;
   logic [START_W-1:0]       mul_b;
   logic signed [PROD_W-1:0] mul_p;

   assign mul_a = (state_ff == ST_MUL_XS || state_ff == ST_MUL_XD) ? cos_ff : sin_ff;
   assign mul_b = (state_ff == ST_MUL_XS || state_ff == ST_MUL_YS) ? start_ff
                                                                  : START_W'(step_ff);
   assign mul_p = PROD_W'(mul_a) * PROD_W'(signed'({1'b0, mul_b}));

   // cell lookup of the current sample
   logic [PIX_W-1:0]  pix_x;
   logic [PIX_W-1:0]  pix_y;
   logic [CELL_W-1:0] col_cnt;
   logic [CELL_W-1:0] row_cnt;
   logic [CELL_W-1:0] cell_idx;
   logic              outside;
   logic              is_wall;

   assign pix_x = px_ff[POS_W-2:FRAC_W];
   assign pix_y = py_ff[POS_W-2:FRAC_W];

   always_comb begin
      col_cnt = '0;
      row_cnt = '0;
      for (int j = 1; j < MAP_COLUMNS; j++) begin
         col_cnt = col_cnt + CELL_W'(pix_x >= PIX_W'(j * CELL_SIZE));
      end
      for (int j = 1; j < MAP_ROWS; j++) begin
         row_cnt = row_cnt + CELL_W'(pix_y >= PIX_W'(j * CELL_SIZE));
      end
   end

   assign cell_idx = CELL_W'(row_cnt * CELL_W'(MAP_COLUMNS)) + col_cnt;
   assign outside  = px_ff[POS_W-1] || py_ff[POS_W-1]
                     || (pix_x >= PIX_W'(MAP_COLUMNS * CELL_SIZE))
                     || (pix_y >= PIX_W'(MAP_ROWS * CELL_SIZE));
   assign is_wall  = !outside && wall_map_ff[cell_idx];

   logic signed [PROD_W-1:0] x_inc;
   logic signed [PROD_W-1:0] y_inc;
   logic                     march_done;

   assign x_inc      = (steps_ff == '0) ? xs_ff : xd_ff;
   assign y_inc      = (steps_ff == '0) ? ys_ff : yd_ff;
   assign march_done = outside || is_wall || (steps_ff == STEPS_W'(MAX_STEPS));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ang_in       = ang_ff;
      neg_in       = neg_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      xs_in        = xs_ff;
      xd_in        = xd_ff;
      ys_in        = ys_ff;
      yd_in        = yd_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               ang_in   = req_data.ray_angle;
               px_in    = signed'(POS_W'({req_data.origin_x, {Q8_SHIFT{1'b0}}}));
               py_in    = signed'(POS_W'({req_data.origin_y, {Q8_SHIFT{1'b0}}}));
               steps_in = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if ({1'b0, ang_ff} >= IDX_W'(ANGLE_STEPS)) begin
               ang_in = ang_ff - ANGLE_W'(ANGLE_STEPS);
            end else begin
               state_in = ST_RD_SIN;
            end
         end
         ST_RD_SIN: begin
            neg_in   = sin_fold[ROM_AW];
            state_in = ST_RD_COS;
         end
         ST_RD_COS: begin
            sin_in   = rom_trig_signed;
            neg_in   = cos_fold[ROM_AW];
            state_in = ST_LD_COS;
         end
         ST_LD_COS: begin
            cos_in   = rom_trig_signed;
            state_in = ST_MUL_XS;
         end
         ST_MUL_XS: begin
            xs_in    = mul_p;
            state_in = ST_MUL_XD;
         end
         ST_MUL_XD: begin
            xd_in    = mul_p;
            state_in = ST_MUL_YS;
         end
         ST_MUL_YS: begin
            ys_in    = mul_p;
            state_in = ST_MUL_YD;
         end
         ST_MUL_YD: begin
            yd_in    = mul_p;
            state_in = ST_MARCH;
         end
         ST_MARCH: begin
            if (march_done) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.end_x       = to_q8(px_ff);
                  rsp_data_in.end_y       = to_q8(py_ff);
                  rsp_data_in.angle_out   = req_ff.ray_angle;
                  rsp_data_in.outcome     = is_wall ? OUTCOME_WALL
                                            : (outside ? OUTCOME_EXIT : OUTCOME_LIMIT);
                  rsp_data_in.steps_taken = steps_ff;
                  state_in                = ST_IDLE;
               end
            end else begin
               px_in    = px_ff + POS_W'(x_inc);
               py_in    = py_ff - POS_W'(y_inc);
               steps_in = steps_ff + STEPS_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
      end
      req_ff      <= req_in;
      ang_ff      <= ang_in;
      neg_ff      <= neg_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      xs_ff       <= xs_in;
      xd_ff       <= xd_in;
      ys_ff       <= ys_in;
      yd_ff       <= yd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEPS_W'(MAX_STEPS))
      else $error("march step count above limit");

   a_limit_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.outcome == OUTCOME_LIMIT
      |-> rsp_data_ff.steps_taken == STEPS_W'(MAX_STEPS))
      else $error("step limit beat without full step count");

   a_rsp_from_march: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MARCH))
      else $error("response beat raised outside the march");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_valid |=> state_ff == ST_REDUCE)
      else $error("accepted request did not start the sequencer");
`endif

endmodule

`default_nettype wire

[verif/grid_ray_march_checker.sv]
// ---------------------------------------------------------------------------
// grid_ray_march_checker: scoreboard for the grid ray march core
// Tracks the march registers from the write port, marches every accepted ray
// in software and compares each response beat, field by field, with the
// oldest predicted ray end. Reports mismatches and the number still due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_ray_march_checker
   import grm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    rays_due,
   output int                    wall_ends,
   output int                    exit_ends,
   output int                    limit_ends
);

   typedef enum logic [1:0] {CELL_FREE, CELL_WALL, CELL_OUTSIDE} cell_kind_type;

   localparam int TURN = ANGLE_STEPS_DEF;

   logic [MAP_W-1:0]   walls      = WALL_MAP_RST;
   logic [START_W-1:0] first_dist = MARCH_START_RST;
   logic [STEP_W-1:0]  dist_step  = MARCH_STEP_RST;
   rsp_type            ray_ends_due [$];

   // first-quadrant sine, Q1.14 magnitude from a Q2.30 Taylor sum
   function automatic longint quarter_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      x    = (TWO_PI_Q30 * 64'(k)) / 64'(TURN);
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return (sum + 64'sd32768) >>> 16;
   endfunction

   function automatic longint sine_q14(input int unsigned k);
      int unsigned q;
      int unsigned a;
      q = TURN / 4;
      a = k % TURN;
      if (a <= q) begin
         return quarter_sine(a);
      end else if (a <= 2 * q) begin
         return quarter_sine(2 * q - a);
      end else if (a <= 3 * q) begin
         return -quarter_sine(a - 2 * q);
      end
      return -quarter_sine(4 * q - a);
   endfunction

   // positions in 2^-30 pixel
   function automatic cell_kind_type cell_at(input longint px, input longint py);
      longint col;
      longint row;
      if (px < 0 || py < 0) begin
         return CELL_OUTSIDE;
      end
      col = (px >>> FRAC_W) / CELL_SIZE;
      row = (py >>> FRAC_W) / CELL_SIZE;
      if (col >= MAP_COLUMNS || row >= MAP_ROWS) begin
         return CELL_OUTSIDE;
      end
      return walls[row * MAP_COLUMNS + col] ? CELL_WALL : CELL_FREE;
   endfunction

   function automatic logic [COORD_W-1:0] to_q8_pixels(input longint p);
      if (p < 0) begin
         return '0;
      end
      if ((p >>> Q8_SHIFT) > longint'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return COORD_W'(p >>> Q8_SHIFT);
   endfunction

   function automatic rsp_type march_ray(input req_type ray);
      rsp_type       hit;
      cell_kind_type kind;
      longint        dir_x;
      longint        dir_y;
      longint        base_x;
      longint        base_y;
      longint        px;
      longint        py;
      longint        reach;
      int            samples;
      dir_x   = sine_q14(32'(ray.ray_angle) + TURN / 4);
      dir_y   = sine_q14(32'(ray.ray_angle));
      base_x  = longint'(ray.origin_x) << Q8_SHIFT;
      base_y  = longint'(ray.origin_y) << Q8_SHIFT;
      px      = base_x;
      py      = base_y;
      reach   = longint'(first_dist);
      samples = 0;
      kind    = cell_at(base_x, base_y);
      if (kind == CELL_FREE) begin
         while (samples < MAX_STEPS) begin
            px = base_x + dir_x * reach;
            py = base_y - dir_y * reach;
            samples++;
            kind = cell_at(px, py);
            if (kind != CELL_FREE) begin
               break;
            end
            reach = reach + longint'(dist_step);
         end
      end
      case (kind)
         CELL_WALL:    hit.outcome = OUTCOME_WALL;
         CELL_OUTSIDE: hit.outcome = OUTCOME_EXIT;
         default:      hit.outcome = OUTCOME_LIMIT;
      endcase
      hit.end_x       = to_q8_pixels(px);
      hit.end_y       = to_q8_pixels(py);
      hit.angle_out   = ray.ray_angle;
      hit.steps_taken = STEPS_W'(samples);
      return hit;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         walls      = WALL_MAP_RST;
         first_dist = MARCH_START_RST;
         dist_step  = MARCH_STEP_RST;
         ray_ends_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WALL_MAP:    walls      = csr_wdata[MAP_W-1:0];
               CSR_MARCH_START: first_dist = csr_wdata[START_W-1:0];
               CSR_MARCH_STEP:  dist_step  = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            ray_ends_due.push_back(march_ray(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (ray_ends_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: ray end beat with no ray in flight: x=%0d y=%0d angle=%0d",
                           $time, rsp_data.end_x, rsp_data.end_y, rsp_data.angle_out);
               end
            end else begin
               want = ray_ends_due.pop_front();
               case (want.outcome)
                  OUTCOME_WALL: wall_ends++;
                  OUTCOME_EXIT: exit_ends++;
                  default:      limit_ends++;
               endcase
               if (rsp_data.end_x !== want.end_x || rsp_data.end_y !== want.end_y ||
                   rsp_data.angle_out !== want.angle_out ||
                   rsp_data.outcome !== want.outcome ||
                   rsp_data.steps_taken !== want.steps_taken) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: ray end mismatch", $time);
                     $display("   expected x=%0d y=%0d angle=%0d outcome=%0d steps=%0d",
                              want.end_x, want.end_y, want.angle_out, want.outcome,
                              want.steps_taken);
                     $display("   actual   x=%0d y=%0d angle=%0d outcome=%0d steps=%0d",
                              rsp_data.end_x, rsp_data.end_y, rsp_data.angle_out,
                              rsp_data.outcome, rsp_data.steps_taken);
                  end
               end
            end
         end
      end
      rays_due <= ray_ends_due.size();
   end

endmodule

[verif/grid_ray_march_core_tb.sv]
// ---------------------------------------------------------------------------
// grid_ray_march_core_tb: top-level bench for the grid ray march core
// Casts directed rays at the walls, off every map edge and into the step
// limit, then random rays over random wall maps and march settings, with
// random idling on both channels. The checker scores every ray end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_ray_march_core_tb;
   import grm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_MAX = 18;
   localparam int CELL_Q8  = CELL_SIZE * 256;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int               mismatches;
   int               rays_due;
   int               wall_ends;
   int               exit_ends;
   int               limit_ends;
   logic [MAP_W-1:0] map_now       = WALL_MAP_RST;
   bit               calm          = 1'b0;
   int               rays_sent     = 0;
   int               settings_used = 1;
   int               stall_left    = 0;

   always #1 clock = ~clock;

   grid_ray_march_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   grid_ray_march_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .rays_due   (rays_due),
      .wall_ends  (wall_ends),
      .exit_ends  (exit_ends),
      .limit_ends (limit_ends)
   );

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   // stall counts down only while a beat is offered
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         stall_left = idle_draw();
      end else if (rsp_valid && stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   function automatic req_type ray_at(input int x, input int y, input int angle);
      req_type r;
      r.origin_x  = COORD_W'(x);
      r.origin_y  = COORD_W'(y);
      r.ray_angle = ANGLE_W'(angle);
      return r;
   endfunction

   function automatic req_type random_ray(input bit aim_free);
      req_type r;
      int      map_cell;
      r = ray_at($urandom_range(0, 131071), $urandom_range(0, 131071),
                 $urandom_range(0, 4095));
      if (aim_free) begin
         for (int tries = 0; tries < 32; tries++) begin
            map_cell = $urandom_range(0, MAP_COLUMNS * MAP_ROWS - 1);
            if (!map_now[map_cell]) begin
               r.origin_x = COORD_W'((map_cell % MAP_COLUMNS) * CELL_Q8 +
                                     $urandom_range(0, CELL_Q8 - 1));
               r.origin_y = COORD_W'((map_cell / MAP_COLUMNS) * CELL_Q8 +
                                     $urandom_range(0, CELL_Q8 - 1));
               break;
            end
         end
      end
      return r;
   endfunction

   task automatic launch_ray(input req_type ray);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ray;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rays_sent++;
   endtask

   task automatic wait_rays_home();
      req_valid <= 1'b0;
      do @(posedge clock); while (rays_due != 0);
   endtask

   // upper data bits beyond each register are junk on purpose
   task automatic program_march(input logic [MAP_W-1:0] walls,
                                input logic [START_W-1:0] start,
                                input logic [STEP_W-1:0] step);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WALL_MAP;
      csr_wdata <= walls;
      @(posedge clock);
      csr_index <= CSR_MARCH_START;
      csr_wdata <= {$urandom, 10'($urandom), start};
      @(posedge clock);
      csr_index <= CSR_MARCH_STEP;
      csr_wdata <= {$urandom, 16'($urandom), step};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      map_now = walls;
      settings_used++;
   endtask

   initial begin
      logic [MAP_W-1:0]  walls;
      logic [STEP_W-1:0] step_draw;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: bordered map, 18 px start, fine step
      launch_ray(ray_at(0, 0, 0));
      launch_ray(ray_at(131071, 131071, 4095));
      launch_ray(ray_at(65536, 65536, 0));
      launch_ray(ray_at(65536, 65536, 1024));
      launch_ray(ray_at(65536, 65536, 2048));
      launch_ray(ray_at(65536, 65536, 3072));
      launch_ray(ray_at(65536, 65536, 512));
      launch_ray(ray_at(25600, 76800, 1700));

      // open map, coarsest step: leave through each edge, saturate both ways
      wait_rays_home();
      program_march('0, '0, 16'hFFFF);
      launch_ray(ray_at(0, 0, 2048));
      launch_ray(ray_at(0, 0, 1024));
      launch_ray(ray_at(131071, 131071, 0));
      launch_ray(ray_at(131071, 131071, 3072));
      launch_ray(ray_at(65536, 65536, 3584));
      launch_ray(ray_at(0, 131071, 2560));

      // solid map, farthest start, finest step
      wait_rays_home();
      program_march('1, 22'h3FFFFF, 16'd1);
      launch_ray(ray_at(65536, 65536, 100));
      launch_ray(ray_at(0, 0, 0));

      // zero step holds one sample until the step limit
      wait_rays_home();
      program_march('0, '0, '0);
      launch_ray(ray_at(65536, 65536, 777));

      wait_rays_home();
      program_march('0, 22'h3FFFFF, 16'd1);
      launch_ray(ray_at(65536, 65536, 3000));

      wait_rays_home();
      program_march(WALL_MAP_RST, 22'h3FFFFF, 16'hFFFF);
      launch_ray(ray_at(65536, 65536, 1234));
      launch_ray(ray_at(30000, 100000, 3900));

      for (int phase = 0; phase < 4; phase++) begin
         wait_rays_home();
         calm = (phase == 1);
         case (phase)
            0:       walls = WALL_MAP_RST | ({$urandom, $urandom} & {$urandom, $urandom});
            1:       walls = {$urandom, $urandom} & {$urandom, $urandom};
            2:       walls = {$urandom, $urandom} & {$urandom, $urandom} &
                             {$urandom, $urandom};
            default: walls = {$urandom, $urandom};
         endcase
         step_draw = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(4096, 16383))
                                                  : STEP_W'($urandom_range(16384, 65535));
         program_march(walls, START_W'($urandom_range(0, 4194303)), step_draw);
         for (int i = 0; i < 25; i++) begin
            if (i == 12) begin
               wait_rays_home();
            end
            launch_ray(random_ray($urandom_range(0, 3) != 0));
         end
      end

      calm = 1'b0;
      wait_rays_home();
      repeat (40) @(posedge clock);
      $display("%0d rays cast under %0d register settings, with and without idling",
               rays_sent, settings_used);
      $display("ray ends: %0d on a wall, %0d off the map, %0d at the step limit",
               wall_ends, exit_ends, limit_ends);
      if (mismatches == 0 && rays_due == 0) begin
         $display("grid_ray_march_core_tb: clean");
      end else begin
         $display("grid_ray_march_core_tb: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("grid_ray_march_core_tb: errors");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/grm_pkg.sv
hw/rtl/grid_ray_march_core.sv
verif/grid_ray_march_checker.sv
verif/grid_ray_march_core_tb.sv
